// ----- sv/mfom_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfom_pkg
// Shared types and constants of the mecanum field-oriented mixer: the CORDIC
// arctangent table, register indexes and the per-item command record.
// ----------------------------------------------------------------------------
package mfom_pkg;

  localparam int SPEED_W      = 16;
  localparam int OUT_W        = 22;
  localparam int OUT_MAX      = 2097151;
  localparam int OUT_MIN      = -2097152;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 32;
  localparam int Q30_FRAC     = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 32'sd1073741824;

  localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  typedef enum logic [1:0] {
    REG_YAW_ZERO       = 2'd0,
    REG_YAW_REVERSED   = 2'd1,
    REG_FIELD_ORIENTED = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] fwd;
    logic signed [SPEED_W-1:0] lat;
    logic signed [SPEED_W-1:0] rot;
    logic                      lock;
    logic                      quarter;
    logic                      fo;
    quad_t                     quad;
    logic                      exact;
  } cmd_t;

endpackage
`default_nettype wire

// ----- sv/mecanum_field_oriented_mixer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mecanum_field_oriented_mixer_unit
// Mecanum wheel mixer: rotates the translation command by the gimbal angle
// (pipelined CORDIC), mixes it into four wheel targets, scales and saturates.
//
//   channel  signals                                    direction
//   in       in_valid/in_ready, speeds, yaw, lock, tb   into block
//   out      out_valid/out_ready, four wheel targets    out of block
//   cfg      psel/penable/pwrite/paddr/pwdata/prdata    register access
//
// one command enters per cycle while the output is not stalled; the CORDIC
// rotation pipeline does one step per stage
// rst clears all valid bits and loads register reset values
// a stalled output freezes the whole pipeline; in_ready follows it
// ----------------------------------------------------------------------------
module mecanum_field_oriented_mixer_unit
  import mfom_pkg::*;
#(
  parameter int ANGLE_BITS     = 13,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [DATA_W-1:0]             pwdata,
  output logic      [DATA_W-1:0]             prdata,
  output logic                               pready,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SPEED_W-1:0]     forward_speed,
  input  wire logic signed [SPEED_W-1:0]     lateral_speed,
  input  wire logic signed [SPEED_W-1:0]     rotation_term,
  input  wire logic [ANGLE_BITS-1:0]         yaw_encoder,
  input  wire logic                          lock,
  input  wire logic                          turn_back,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [OUT_W-1:0]            front_left,
  output logic signed [OUT_W-1:0]            front_right,
  output logic signed [OUT_W-1:0]            back_left,
  output logic signed [OUT_W-1:0]            back_right
);

  localparam int TF  = TRIG_FRAC_BITS;
  localparam int SH  = Q30_FRAC - TF;
  localparam int PW  = TF + 2;
  localparam int PRW = SPEED_W + PW;
  localparam int RQW = SPEED_W + TF;
  localparam int SW  = PRW + 2;
  localparam int XW  = SW + 4;
  localparam int CN  = CORDIC_STEPS;

  localparam logic signed [CORDIC_W:0] HALF     = (CORDIC_W+1)'(1) <<< (SH - 1);
  localparam logic signed [PW-1:0]     TRIG_ONE = {2'b01, {TF{1'b0}}};
  localparam logic signed [XW-1:0]     BIAS_N   = (XW'(1) <<< TF) - XW'(1);
  localparam logic signed [XW-1:0]     BIAS_Q   = (XW'(1) <<< (TF + 2)) - XW'(1);
  localparam logic signed [XW-1:0]     SAT_HI   = XW'(OUT_MAX);
  localparam logic signed [XW-1:0]     SAT_LO   = XW'(OUT_MIN);

  // configuration registers
  logic [ANGLE_BITS-1:0] yaw_zero;
  logic                  yaw_reversed;
  logic                  field_oriented;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_zero       <= '0;
      yaw_reversed   <= 1'b0;
      field_oriented <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_YAW_ZERO:       yaw_zero       <= pwdata[ANGLE_BITS-1:0];
        REG_YAW_REVERSED:   yaw_reversed   <= pwdata[0];
        REG_FIELD_ORIENTED: field_oriented <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_YAW_ZERO:       prdata = DATA_W'(yaw_zero);
      REG_YAW_REVERSED:   prdata = DATA_W'(yaw_reversed);
      REG_FIELD_ORIENTED: prdata = DATA_W'(field_oriented);
      default:            prdata = '0;
    endcase
  end

  // pipeline advance
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // angle and entry stage
  logic [ANGLE_BITS-1:0] ang;
  logic [CORDIC_W-1:0]   turn;
  cmd_t                  cmd_in;

  assign ang  = yaw_reversed ? (yaw_zero - yaw_encoder) : (yaw_encoder - yaw_zero);
  assign turn = {ang, {(CORDIC_W - ANGLE_BITS){1'b0}}};

  always_comb begin
    cmd_in.fwd     = forward_speed;
    cmd_in.lat     = lateral_speed;
    cmd_in.rot     = rotation_term;
    cmd_in.lock    = lock;
    cmd_in.quarter = turn_back;
    cmd_in.fo      = field_oriented;
    cmd_in.quad    = quad_t'(turn[CORDIC_W-1 -: 2]);
    cmd_in.exact   = (turn[CORDIC_W-3:0] == '0);
  end

  logic [CN:0]                 cv;
  logic signed [CORDIC_W-1:0]  cx [CN+1];
  logic signed [CORDIC_W-1:0]  cy [CN+1];
  logic signed [CORDIC_W-1:0]  cz [CN+1];
  cmd_t                        cc [CN+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= CORDIC_GAIN;
      cy[0] <= '0;
      cz[0] <= {2'b00, turn[CORDIC_W-3:0]};
      cc[0] <= cmd_in;
    end
  end

  // cordic rotation, one step per stage
  for (genvar i = 0; i < CN; i++) begin : g_cordic
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;

    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        cc[i+1] <= cc[i];
        if (!cz[i][CORDIC_W-1]) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ATAN_TURNS[i];
        end else begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ATAN_TURNS[i];
        end
      end
    end
  end

  // quadrant fold and cos+sin / cos-sin
  logic signed [CORDIC_W-1:0] xf;
  logic signed [CORDIC_W-1:0] yf;
  logic signed [CORDIC_W-1:0] cosv;
  logic signed [CORDIC_W-1:0] sinv;
  logic signed [CORDIC_W:0]   psum;
  logic signed [CORDIC_W:0]   msum;
  logic signed [CORDIC_W:0]   pround;
  logic signed [CORDIC_W:0]   mround;

  assign xf = cc[CN].exact ? ONE_Q30 : cx[CN];
  assign yf = cc[CN].exact ? '0 : cy[CN];

  always_comb begin
    case (cc[CN].quad)
      QUAD_II: begin
        cosv = -yf;
        sinv = xf;
      end
      QUAD_III: begin
        cosv = -xf;
        sinv = -yf;
      end
      QUAD_IV: begin
        cosv = yf;
        sinv = -xf;
      end
      default: begin
        cosv = xf;
        sinv = yf;
      end
    endcase
  end

  assign psum   = (CORDIC_W+1)'(cosv) + (CORDIC_W+1)'(sinv);
  assign msum   = (CORDIC_W+1)'(cosv) - (CORDIC_W+1)'(sinv);
  assign pround = (psum + HALF) >>> SH;
  assign mround = (msum + HALF) >>> SH;

  logic                 pm_v;
  cmd_t                 pm_cmd;
  logic signed [PW-1:0] pm_p;
  logic signed [PW-1:0] pm_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      pm_cmd <= cc[CN];
      pm_p   <= cc[CN].fo ? pround[PW-1:0] : TRIG_ONE;
      pm_m   <= cc[CN].fo ? mround[PW-1:0] : TRIG_ONE;
    end
  end

  // products
  logic                  pr_v;
  cmd_t                  pr_cmd;
  logic signed [PRW-1:0] pr_fp;
  logic signed [PRW-1:0] pr_fm;
  logic signed [PRW-1:0] pr_lp;
  logic signed [PRW-1:0] pr_lm;
  logic signed [RQW-1:0] pr_rq;

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_cmd <= pm_cmd;
      pr_fp  <= pm_cmd.fwd * pm_p;
      pr_fm  <= pm_cmd.fwd * pm_m;
      pr_lp  <= pm_cmd.lat * pm_p;
      pr_lm  <= pm_cmd.lat * pm_m;
      pr_rq  <= {pm_cmd.rot, {TF{1'b0}}};
    end
  end

  // wheel sums
  logic                 sm_v;
  cmd_t                 sm_cmd;
  logic signed [SW-1:0] sm_fl;
  logic signed [SW-1:0] sm_fr;
  logic signed [SW-1:0] sm_bl;
  logic signed [SW-1:0] sm_br;

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_cmd <= pr_cmd;
      sm_fl  <= SW'(pr_fp) + SW'(pr_lm) + SW'(pr_rq);
      sm_fr  <= SW'(pr_lp) - SW'(pr_fm) + SW'(pr_rq);
      sm_bl  <= SW'(pr_fm) - SW'(pr_lp) + SW'(pr_rq);
      sm_br  <= SW'(pr_rq) - SW'(pr_fp) - SW'(pr_lm);
    end
  end

  // times twelve
  logic                 sc_v;
  cmd_t                 sc_cmd;
  logic signed [XW-1:0] sc_fl;
  logic signed [XW-1:0] sc_fr;
  logic signed [XW-1:0] sc_bl;
  logic signed [XW-1:0] sc_br;

  function automatic logic signed [XW-1:0] times12(input logic signed [SW-1:0] v);
    logic signed [XW-1:0] w;
    w = XW'(v);
    return (w <<< 3) + (w <<< 2);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_cmd <= sm_cmd;
      sc_fl  <= times12(sm_fl);
      sc_fr  <= times12(sm_fr);
      sc_bl  <= times12(sm_bl);
      sc_br  <= times12(sm_br);
    end
  end

  // divide toward zero and saturate
  function automatic logic signed [OUT_W-1:0] wheel_out(input logic signed [XW-1:0] v,
                                                        input logic quarter);
    logic signed [XW-1:0] b;
    logic signed [XW-1:0] d;
    if (quarter) begin
      b = v[XW-1] ? BIAS_Q : '0;
      d = (v + b) >>> (TF + 2);
    end else begin
      b = v[XW-1] ? BIAS_N : '0;
      d = (v + b) >>> TF;
    end
    if (d > SAT_HI) begin
      d = SAT_HI;
    end else if (d < SAT_LO) begin
      d = SAT_LO;
    end
    return d[OUT_W-1:0];
  endfunction

  logic out_lock;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lock    <= sc_cmd.lock;
      front_left  <= sc_cmd.lock ? '0 : wheel_out(sc_fl, sc_cmd.quarter);
      front_right <= sc_cmd.lock ? '0 : wheel_out(sc_fr, sc_cmd.quarter);
      back_left   <= sc_cmd.lock ? '0 : wheel_out(sc_bl, sc_cmd.quarter);
      back_right  <= sc_cmd.lock ? '0 : wheel_out(sc_br, sc_cmd.quarter);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      cv        <= '0;
      pm_v      <= 1'b0;
      pr_v      <= 1'b0;
      sm_v      <= 1'b0;
      sc_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      cv        <= {cv[CN-1:0], in_valid};
      pm_v      <= cv[CN];
      pr_v      <= pm_v;
      sm_v      <= pr_v;
      sc_v      <= sm_v;
      out_valid <= sc_v;
    end
  end

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid && (cv == '0) && !pm_v && !pr_v && !sm_v && !sc_v)
    else $error("pipeline not empty after reset");

  a_entry_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> cv[0])
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(cv) && $stable(pm_v) && $stable(pr_v) && $stable(sm_v)
             && $stable(sc_v))
    else $error("pipeline moved during a stall");

  a_plain_trig: assert property (@(posedge clk) disable iff (rst)
    pm_v && !pm_cmd.fo |-> (pm_p == TRIG_ONE) && (pm_m == TRIG_ONE))
    else $error("trig terms not unity with field orientation off");

  a_lock_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_lock |-> (front_left == '0) && (front_right == '0)
                             && (back_left == '0) && (back_right == '0))
    else $error("locked transfer produced nonzero wheel targets");
`endif

endmodule
`default_nettype wire
